@@ hdl/lcs_pkg.sv @@
// shared types and constants for the line centroid steering block
package lcs_pkg;

	localparam int ROW_WIDTH   = 320;
	localparam int PIX_W       = 8;
	localparam int COL_W       = 12;
	localparam int SUM_W       = 24;
	localparam int CNT_W       = 12;
	localparam int SPEED_W     = 9;
	localparam int OFFSET_W    = 12;
	localparam int CFG_W       = 8;
	localparam int CFG_IDX_W   = 1;
	localparam int IN_DATA_W   = 8;
	localparam int OUT_DATA_W  = 32;
	localparam int SPEED_LIMIT = 255;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WHITE_THRESHOLD = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_SPEED      = 1'd1;

	localparam logic [CFG_W-1:0] WHITE_THRESHOLD_RST = 8'd120;
	localparam logic [CFG_W-1:0] BASE_SPEED_RST      = 8'd80;

	// floor(x / 5) == (x * DIV5_MUL) >> DIV5_SHIFT for x below 2**16
	localparam int DIV5_MUL   = 52429;
	localparam int DIV5_SHIFT = 18;

	typedef struct packed {
		logic take;
		logic div_step;
		logic post1;
		logic post2;
		logic out_load;
	} lcs_cmd_t;

	typedef struct packed {
		logic row_last;
		logic row_empty;
		logic div_done;
		logic out_free;
	} lcs_status_t;

endpackage

@@ hdl/lcs_ctrl.sv @@
// controller: row accumulation, divide sequencing and result hand-off
module lcs_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  lcs_pkg::lcs_status_t status,
	output lcs_pkg::lcs_cmd_t    cmd
);
	import lcs_pkg::*;

	localparam logic [2:0] ST_ACC = 3'd0;
	localparam logic [2:0] ST_DIV = 3'd1;
	localparam logic [2:0] ST_P1  = 3'd2;
	localparam logic [2:0] ST_P2  = 3'd3;
	localparam logic [2:0] ST_P3  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_ready = (state_q == ST_ACC);

	always_comb begin
		cmd          = '0;
		state_d      = state_q;
		cmd.take     = in_ready && in_valid;
		cmd.div_step = (state_q == ST_DIV);
		cmd.post1    = (state_q == ST_P1);
		cmd.post2    = (state_q == ST_P2);
		cmd.out_load = (state_q == ST_P3) && status.out_free;
		case (state_q)
			ST_ACC: begin
				if (cmd.take && status.row_last) begin
					// an empty row skips the divide
					state_d = status.row_empty ? ST_P1 : ST_DIV;
				end
			end
			ST_DIV: begin
				if (status.div_done) begin
					state_d = ST_P1;
				end
			end
			ST_P1: state_d = ST_P2;
			ST_P2: state_d = ST_P3;
			ST_P3: begin
				if (status.out_free) begin
					state_d = ST_ACC;
				end
			end
			default: state_d = ST_ACC;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACC;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ hdl/lcs_datapath.sv @@
// datapath: accumulators, serial divider, steering math and output register
module lcs_datapath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [lcs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lcs_pkg::CFG_W-1:0]       cfg_data,
	input  logic [lcs_pkg::PIX_W-1:0]       pixel_value,
	input  logic                            row_end,
	input  lcs_pkg::lcs_cmd_t               cmd,
	output lcs_pkg::lcs_status_t            status,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic signed [lcs_pkg::SPEED_W-1:0]  left_speed,
	output logic signed [lcs_pkg::SPEED_W-1:0]  right_speed,
	output logic signed [lcs_pkg::OFFSET_W-1:0] line_offset,
	output logic                            no_line
);
	import lcs_pkg::*;

	localparam int STEP_W = $clog2(SUM_W);
	localparam int PROD_W = 18;
	localparam int X_W    = PROD_W - 4;
	localparam int MUL_W  = X_W + 16;
	localparam int Q5_W   = 12;
	localparam int D_W    = 13;

	logic [CFG_W-1:0]        thr_q;
	logic [CFG_W-1:0]        base_q;
	logic [COL_W-1:0]        col_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0]        cnt_q;

	logic [SUM_W-1:0]        dvd_q;
	logic [CNT_W-1:0]        dvs_q;
	logic [CNT_W-1:0]        rem_q;
	logic [STEP_W-1:0]       step_q;
	logic                    neg_q;
	logic                    empty_q;

	logic signed [OFFSET_W-1:0] mean_q;
	logic [PROD_W-1:0]          prod_q;
	logic [Q5_W-1:0]            quot5_q;
	logic                       valid_q;

	logic                    hit;
	logic signed [SUM_W-1:0] offset;
	logic signed [SUM_W-1:0] sum_new;
	logic [CNT_W-1:0]        cnt_new;
	logic [SUM_W-1:0]        sum_abs;
	logic [CNT_W:0]          shifted;
	logic                    ge;
	logic [CNT_W:0]          rem_next;
	logic [OFFSET_W-1:0]     mag;
	logic [OFFSET_W-2:0]     halfm;
	logic [MUL_W-1:0]        mul5;
	logic [Q5_W-2:0]         dm;
	logic signed [D_W-1:0]   dsig;
	logic signed [D_W-1:0]   lsum;
	logic signed [D_W-1:0]   rsum;

	function automatic logic signed [SPEED_W-1:0] clamp_speed(input logic signed [D_W-1:0] v);
		logic signed [D_W-1:0] lim;
		lim = D_W'(SPEED_LIMIT);
		if (v > lim) begin
			clamp_speed = SPEED_W'(SPEED_LIMIT);
		end else if (v < -lim) begin
			clamp_speed = -SPEED_W'(SPEED_LIMIT);
		end else begin
			clamp_speed = v[SPEED_W-1:0];
		end
	endfunction

	// accumulation of the current pixel
	always_comb begin
		hit     = pixel_value > thr_q;
		offset  = $signed(SUM_W'(col_q)) - SUM_W'(ROW_WIDTH / 2);
		sum_new = hit ? sum_q + offset : sum_q;
		cnt_new = cnt_q + CNT_W'(hit);
		sum_abs = sum_new[SUM_W-1] ? SUM_W'(-sum_new) : SUM_W'(sum_new);
	end

	// one restoring divide step per cycle
	always_comb begin
		shifted  = {rem_q, dvd_q[SUM_W-1]};
		ge       = shifted >= {1'b0, dvs_q};
		rem_next = ge ? shifted - {1'b0, dvs_q} : shifted;
	end

	always_comb begin
		mag   = dvd_q[OFFSET_W-1:0];
		halfm = mag[OFFSET_W-1:1];
		mul5  = MUL_W'(prod_q[PROD_W-1:4]) * MUL_W'(DIV5_MUL);
		dm    = quot5_q[Q5_W-1:1];
		dsig  = neg_q ? -D_W'(dm) : D_W'(dm);
		lsum  = $signed(D_W'(base_q)) + dsig;
		rsum  = $signed(D_W'(base_q)) - dsig;
	end

	always_comb begin
		status.row_last  = row_end || (col_q >= COL_W'(ROW_WIDTH - 1));
		status.row_empty = (cnt_new == '0);
		status.div_done  = (step_q == STEP_W'(SUM_W - 1));
		status.out_free  = !valid_q || out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= WHITE_THRESHOLD_RST;
			base_q <= BASE_SPEED_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WHITE_THRESHOLD: thr_q  <= cfg_data;
				REG_BASE_SPEED:      base_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			sum_q <= '0;
			cnt_q <= '0;
		end else if (cmd.take) begin
			if (status.row_last) begin
				col_q <= '0;
				sum_q <= '0;
				cnt_q <= '0;
			end else begin
				col_q <= col_q + COL_W'(1);
				sum_q <= sum_new;
				cnt_q <= cnt_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take && status.row_last) begin
			dvd_q   <= status.row_empty ? '0 : sum_abs;
			dvs_q   <= cnt_new;
			rem_q   <= '0;
			step_q  <= '0;
			neg_q   <= sum_new[SUM_W-1];
			empty_q <= status.row_empty;
		end else if (cmd.div_step) begin
			dvd_q  <= {dvd_q[SUM_W-2:0], ge};
			rem_q  <= rem_next[CNT_W-1:0];
			step_q <= step_q + STEP_W'(1);
		end
		if (cmd.post1) begin
			mean_q <= neg_q ? -$signed(mag) : $signed(mag);
			prod_q <= PROD_W'({halfm, 8'b0}) - PROD_W'(halfm);
		end
		if (cmd.post2) begin
			quot5_q <= mul5[DIV5_SHIFT +: Q5_W];
		end
		if (cmd.out_load) begin
			left_speed  <= clamp_speed(lsum);
			right_speed <= clamp_speed(rsum);
			line_offset <= mean_q;
			no_line     <= empty_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	assign out_valid = valid_q;

endmodule

@@ hdl/line_centroid_steering_top.sv @@
// Line centroid steering: one pixel per input transaction, one steering result per row.
// s_tdata[7:0] is the pixel brightness, s_tlast marks the last pixel of a row.
// A row also ends on its own at column ROW_WIDTH-1.
// m_tdata carries left speed [8:0], right speed [17:9], mean line offset [29:18],
// zero padding [31:30]; m_tuser[0] is set when no pixel passed the threshold.
// cfg_we/cfg_index/cfg_data write white_threshold (index 0) or base_speed (index 1);
// write only while no row is in flight.
// Inside a row a pixel is taken every cycle. After the row's last pixel the
// input stalls while a bit-serial divider forms the mean, one quotient bit
// per divide step, then the steering math and the output load follow (a row
// without line pixels skips the divide). Then the next row may start.
// The result sits in an output register, so a stalled receiver only holds the
// block once a second result is ready to be loaded.
// Reset clears the accumulators, drops m_tvalid and restores the registers to
// threshold 120 and base speed 80.
module line_centroid_steering_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [lcs_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [lcs_pkg::CFG_W-1:0]             cfg_data,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [lcs_pkg::IN_DATA_W-1:0]         s_tdata,   // pixel_value
	input  logic                                  s_tlast,   // row_end
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// left_speed, right_speed, line_offset, zero fill
	output logic [lcs_pkg::OUT_DATA_W-1:0]        m_tdata,
	output logic [0:0]                            m_tuser    // no_line
);
	import lcs_pkg::*;

	lcs_cmd_t    cmd;
	lcs_status_t status;

	logic signed [SPEED_W-1:0]  left_speed;
	logic signed [SPEED_W-1:0]  right_speed;
	logic signed [OFFSET_W-1:0] line_offset;
	logic                       no_line;

	lcs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	lcs_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.pixel_value (s_tdata[PIX_W-1:0]),
		.row_end     (s_tlast),
		.cmd         (cmd),
		.status      (status),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.left_speed  (left_speed),
		.right_speed (right_speed),
		.line_offset (line_offset),
		.no_line     (no_line)
	);

	assign m_tdata = {
		(OUT_DATA_W - 2*SPEED_W - OFFSET_W)'(0),
		line_offset, right_speed, left_speed
	};
	assign m_tuser = no_line;

`ifndef NO_ASSERTIONS
	// input is never taken while the divider or steering math is busy
	a_no_take_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.div_step || cmd.post1 || cmd.post2) |-> !s_tready)
		else $error("input accepted during result computation");

	// an empty row reports zero offset and equal speeds
	a_empty_row: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |->
		(line_offset == '0) && (left_speed == right_speed))
		else $error("empty row result inconsistent");

	// speeds do not fall below the negative motor limit
	a_speed_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (left_speed >= -SPEED_W'(SPEED_LIMIT)) &&
		(right_speed >= -SPEED_W'(SPEED_LIMIT)))
		else $error("speed below limit");

	// a new result only appears after a load from the controller
	a_valid_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(cmd.out_load))
		else $error("result valid without load");
`endif

endmodule
